// ===== src/tcw_pkg.sv =====
package tcw_pkg;

   // Default grid size
   localparam int COLS_DEF = 80;
   localparam int ROWS_DEF = 25;

   // Port widths
   localparam int ACTION_W  = 2;
   localparam int CHAR_W    = 8;
   localparam int COLOR_W   = 8;
   localparam int ROW_IN_W  = 5;
   localparam int COL_IN_W  = 7;
   localparam int CELL_W    = CHAR_W + COLOR_W;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   // Character and attribute constants
   localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
   localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd15;

endpackage

// ===== src/text_console_writer.sv =====
// Text console: a ROWS x COLS grid of cells (character byte, attribute byte) in one
// simple dual-port RAM, plus a cursor. Raise req_start with an action while busy is
// low; the transfer happens at that edge. Every action gives exactly one result,
// shown on the rsp_ ports for a single cycle while rsp_strobe is high; the receiver
// cannot stall it, so sample it on that cycle. A clear sweeps the RAM one cell per
// cycle. A newline on the bottom row scrolls: the RAM port copies each cell one row
// up and blanks the bottom row, one cell per cycle. The single RAM write port sets
// these rates. After reset a clearing pass fills the grid with spaces in color 15;
// busy stays high meanwhile, while csr_write_en still writes text_color at any time.
module text_console_writer #(
   parameter int COLS = tcw_pkg::COLS_DEF,
   parameter int ROWS = tcw_pkg::ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request
   input  logic                          req_start,
   output logic                          busy,
   input  logic [tcw_pkg::ACTION_W-1:0]  req_action,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcw_pkg::ROW_IN_W-1:0]  req_read_row,
   input  logic [tcw_pkg::COL_IN_W-1:0]  req_read_col,
   // response
   output logic                          rsp_strobe,
   output logic [tcw_pkg::CHAR_W-1:0]    rsp_cell_char,
   output logic [tcw_pkg::COLOR_W-1:0]   rsp_cell_color,
   output logic [tcw_pkg::ROW_IN_W-1:0]  rsp_cursor_row_out,
   output logic [tcw_pkg::COL_IN_W-1:0]  rsp_cursor_col_out,
   // configuration
   input  logic                          csr_write_en,
   input  logic [tcw_pkg::COLOR_W-1:0]   csr_write_data
);

   import tcw_pkg::*;

   localparam int NCELLS = ROWS * COLS;
   localparam int ADDR_W = $clog2(NCELLS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLS);
   // the scroll counter walks source addresses COLS .. NCELLS+COLS-1
   localparam int CNT_W  = $clog2(NCELLS + COLS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUT,
      ST_RD_ISSUE,
      ST_RD_WAIT,
      ST_CLEAR,
      ST_SCROLL,
      ST_SCROLL_END
   } state_type;

   state_type            state_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [ADDR_W-1:0]    wr_addr_ff;
   logic                 wr_pend_ff;
   logic                 copy_pend_ff;
   logic                 init_ff;
   logic [CHAR_W-1:0]    char_ff;
   logic [COLOR_W-1:0]   color_ff;
   logic [COLOR_W-1:0]   text_color_ff;
   logic [ROW_W-1:0]     cursor_row_ff;
   logic [COL_W-1:0]     cursor_col_ff;
   logic                 rsp_strobe_ff;
   logic [CHAR_W-1:0]    rsp_char_ff;
   logic [COLOR_W-1:0]   rsp_color_ff;

   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [CELL_W-1:0]    mem_wdata;
   logic [ADDR_W-1:0]    mem_raddr;
   logic [CELL_W-1:0]    mem_rdata;

   logic                 accept;
   logic                 read_in_grid;
   logic [ADDR_W-1:0]    read_addr;
   logic [ADDR_W-1:0]    cursor_addr;
   logic [CELL_W-1:0]    blank_cell;
   logic                 src_in_grid;

   assign accept       = req_start && !busy;
   assign read_in_grid = (32'(req_read_row) < ROWS) && (32'(req_read_col) < COLS);
   assign read_addr    = ADDR_W'(ADDR_W'(req_read_row) * ADDR_W'(COLS)
                                 + ADDR_W'(req_read_col));
   assign cursor_addr  = ADDR_W'(ADDR_W'(cursor_row_ff) * ADDR_W'(COLS)
                                 + ADDR_W'(cursor_col_ff));
   assign blank_cell   = {color_ff, SPACE_CODE};
   assign src_in_grid  = 32'(cnt_ff) < NCELLS;

   // Text color register: written whenever the CSR strobe is up.
   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= RESET_COLOR;
      end else if (csr_write_en) begin
         text_color_ff <= csr_write_data;
      end
   end

   // RAM port control. A pending scroll write always owns the write port; it
   // lands in the cycle after its source cell was read.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      if (wr_pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = wr_addr_ff;
         mem_wdata = copy_pend_ff ? mem_rdata : blank_cell;
      end else begin
         unique case (state_ff)
            ST_PUT: begin
               if (char_ff != NEWLINE_CODE) begin
                  mem_we    = 1'b1;
                  mem_waddr = cursor_addr;
                  mem_wdata = {color_ff, char_ff};
               end
            end
            ST_CLEAR: begin
               mem_we    = 1'b1;
               mem_waddr = ADDR_W'(cnt_ff);
               mem_wdata = blank_cell;
            end
            default: begin
            end
         endcase
      end
      mem_raddr = (state_ff == ST_SCROLL) ? ADDR_W'(cnt_ff) : addr_ff;
   end

   // Sequencer with cursor and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         color_ff      <= RESET_COLOR;
         init_ff       <= 1'b1;
         wr_pend_ff    <= 1'b0;
         copy_pend_ff  <= 1'b0;
         cursor_row_ff <= '0;
         cursor_col_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         wr_pend_ff    <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  char_ff      <= req_char_code;
                  color_ff     <= text_color_ff;
                  addr_ff      <= read_addr;
                  cnt_ff       <= '0;
                  rsp_char_ff  <= '0;
                  rsp_color_ff <= '0;
                  unique case (req_action)
                     ACT_PUT: begin
                        state_ff <= ST_PUT;
                     end
                     ACT_READ: begin
                        if (read_in_grid) begin
                           state_ff <= ST_RD_ISSUE;
                        end else begin
                           rsp_strobe_ff <= 1'b1;
                        end
                     end
                     ACT_CLEAR: begin
                        state_ff <= ST_CLEAR;
                     end
                     default: begin
                        // unused code: report the cursor and nothing else
                        rsp_strobe_ff <= 1'b1;
                     end
                  endcase
               end
            end
            ST_PUT: begin
               if (char_ff == NEWLINE_CODE ||
                   cursor_col_ff == COL_W'(COLS - 1)) begin
                  cursor_col_ff <= '0;
                  if (cursor_row_ff == ROW_W'(ROWS - 1)) begin
                     // new line on the bottom row: scroll, sources start at row 1
                     cnt_ff   <= CNT_W'(COLS);
                     state_ff <= ST_SCROLL;
                  end else begin
                     cursor_row_ff <= cursor_row_ff + ROW_W'(1);
                     rsp_strobe_ff <= 1'b1;
                     state_ff      <= ST_IDLE;
                  end
               end else begin
                  cursor_col_ff <= cursor_col_ff + COL_W'(1);
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_RD_ISSUE: begin
               state_ff <= ST_RD_WAIT;
            end
            ST_RD_WAIT: begin
               rsp_char_ff   <= mem_rdata[CHAR_W-1:0];
               rsp_color_ff  <= mem_rdata[CELL_W-1:CHAR_W];
               rsp_strobe_ff <= 1'b1;
               state_ff      <= ST_IDLE;
            end
            ST_CLEAR: begin
               if (32'(cnt_ff) == NCELLS - 1) begin
                  cursor_row_ff <= '0;
                  cursor_col_ff <= '0;
                  init_ff       <= 1'b0;
                  // the power-up pass gives no result
                  rsp_strobe_ff <= !init_ff;
                  state_ff      <= ST_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            ST_SCROLL: begin
               // read source now, write it one row up next cycle; past the grid
               // the destination is the bottom row and gets blanks
               wr_pend_ff   <= 1'b1;
               copy_pend_ff <= src_in_grid;
               wr_addr_ff   <= ADDR_W'(cnt_ff - CNT_W'(COLS));
               if (32'(cnt_ff) == NCELLS + COLS - 1) begin
                  state_ff <= ST_SCROLL_END;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            ST_SCROLL_END: begin
               // last blank lands this cycle
               rsp_strobe_ff <= 1'b1;
               state_ff      <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (NCELLS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_cell_char      = rsp_char_ff;
   assign rsp_cell_color     = rsp_color_ff;
   assign rsp_cursor_row_out = ROW_IN_W'(cursor_row_ff);
   assign rsp_cursor_col_out = COL_IN_W'(cursor_col_ff);

endmodule

// ===== src/tcw_ram.sv =====
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tcw_checker.sv =====
module tcw_checker #(
   parameter int COLS = tcw_pkg::COLS_DEF,
   parameter int ROWS = tcw_pkg::ROWS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_start,
   input logic                          busy,
   input logic [tcw_pkg::ACTION_W-1:0]  req_action,
   input logic                          rsp_strobe,
   input logic [tcw_pkg::CHAR_W-1:0]    rsp_cell_char,
   input logic [tcw_pkg::COLOR_W-1:0]   rsp_cell_color,
   input logic [tcw_pkg::ROW_IN_W-1:0]  rsp_cursor_row_out,
   input logic [tcw_pkg::COL_IN_W-1:0]  rsp_cursor_col_out
);

   import tcw_pkg::*;

   logic accept;
   assign accept = req_start && !busy;

   // Hold off requests during the power-up clearing pass.
   a_init_busy: assert property (@(posedge clock) $fell(reset) |-> busy)
      else $error("busy low right after reset");

   // The cursor reported is always inside the grid.
   a_cursor_in_grid: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (32'(rsp_cursor_row_out) < ROWS) && (32'(rsp_cursor_col_out) < COLS))
      else $error("cursor reported outside the grid");

   // An unused action code answers at once with an empty cell.
   a_unused_action: assert property (@(posedge clock) disable iff (reset)
      accept && req_action != ACT_PUT && req_action != ACT_READ && req_action != ACT_CLEAR
      |=> rsp_strobe && rsp_cell_char == '0 && rsp_cell_color == '0)
      else $error("unused action not answered with an empty cell");

   // A put always holds busy high, with no reply, in the cycle after its transfer.
   a_put_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_action == ACT_PUT |=> busy && !rsp_strobe)
      else $error("put did not hold busy");

endmodule

bind text_console_writer tcw_checker #(.COLS(COLS), .ROWS(ROWS)) u_tcw_checker (.*);

// ===== test/tb_text_console_writer.sv =====
`timescale 1ns / 1ps

module tb_text_console_writer;
   import tcw_pkg::*;

   localparam int GRID_COLS = COLS_DEF;
   localparam int GRID_ROWS = ROWS_DEF;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int PHASE_ITEMS = 105;
   localparam int RANDOM_PHASES = 6;
   // Worst case: every transfer a scroll or clear plus the longest sender gap,
   // for about 750 transfers, then taken four times over.
   localparam longint TIMEOUT_NS = 64'd120_000_000;

   // One command as it crosses the request ports.
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [CHAR_W-1:0]   char_code;
      logic [ROW_IN_W-1:0] read_row;
      logic [COL_IN_W-1:0] read_col;
   } console_cmd_type;

   // One reply as it leaves the response ports.
   typedef struct packed {
      logic [CHAR_W-1:0]   cell_char;
      logic [COLOR_W-1:0]  cell_color;
      logic [ROW_IN_W-1:0] cursor_row;
      logic [COL_IN_W-1:0] cursor_col;
   } console_rsp_type;

   // A command waiting to be driven, with the idle cycles to spend before it.
   typedef struct {
      console_cmd_type cmd;
      int              lead_gap;
   } pending_cmd_type;

   typedef struct packed {
      logic [CHAR_W-1:0]  glyph;
      logic [COLOR_W-1:0] attr;
   } cell_type;

   logic clock = 1'b0;
   logic reset;
   logic req_start;
   logic busy;
   logic [ACTION_W-1:0] req_action;
   logic [CHAR_W-1:0]   req_char_code;
   logic [ROW_IN_W-1:0] req_read_row;
   logic [COL_IN_W-1:0] req_read_col;
   logic rsp_strobe;
   logic [CHAR_W-1:0]   rsp_cell_char;
   logic [COLOR_W-1:0]  rsp_cell_color;
   logic [ROW_IN_W-1:0] rsp_cursor_row_out;
   logic [COL_IN_W-1:0] rsp_cursor_col_out;
   logic csr_write_en;
   logic [COLOR_W-1:0] csr_write_data;

   // Shadow copy of the console: grid, cursor and pen color.
   cell_type screen [GRID_ROWS][GRID_COLS];
   int unsigned cur_row;
   int unsigned cur_col;
   logic [COLOR_W-1:0] pen_color;

   pending_cmd_type queued_cmds[$];
   console_rsp_type expected_replies[$];
   logic req_taken;
   bit   sender_idles;

   int mismatch_count = 0;
   int reply_count = 0;
   int put_count = 0;
   int read_count = 0;
   int clear_count = 0;
   int unused_count = 0;
   int scroll_count = 0;
   int wrap_count = 0;

   text_console_writer u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_start          (req_start),
      .busy               (busy),
      .req_action         (req_action),
      .req_char_code      (req_char_code),
      .req_read_row       (req_read_row),
      .req_read_col       (req_read_col),
      .rsp_strobe         (rsp_strobe),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cell_color     (rsp_cell_color),
      .rsp_cursor_row_out (rsp_cursor_row_out),
      .rsp_cursor_col_out (rsp_cursor_col_out),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Console predictor
   // ---------------------------------------------------------------------

   function void blank_row(int unsigned r);
      for (int c = 0; c < GRID_COLS; c++) begin
         screen[r][c] = '{glyph: SPACE_CODE, attr: pen_color};
      end
   endfunction

   // Move to column 0 of the next row; on the bottom row shift the grid up
   // one row and blank the freed bottom row in the pen color.
   function void line_feed();
      cur_col = 0;
      if (cur_row < GRID_ROWS - 1) begin
         cur_row++;
         return;
      end
      scroll_count++;
      for (int r = 0; r < GRID_ROWS - 1; r++) begin
         screen[r] = screen[r + 1];
      end
      blank_row(GRID_ROWS - 1);
   endfunction

   // Apply one command to the shadow console and return the reply it gives.
   function console_rsp_type console_outcome(console_cmd_type cmd);
      console_rsp_type rsp;
      rsp = '0;
      unique case (cmd.action)
         ACT_PUT: begin
            if (cmd.char_code == NEWLINE_CODE) begin
               line_feed();
            end else begin
               screen[cur_row][cur_col] = '{glyph: cmd.char_code, attr: pen_color};
               cur_col++;
               // filling the last column wraps at once
               if (cur_col >= GRID_COLS) begin
                  wrap_count++;
                  line_feed();
               end
            end
         end
         ACT_READ: begin
            // reads outside the grid return zeros
            if (cmd.read_row < GRID_ROWS && cmd.read_col < GRID_COLS) begin
               rsp.cell_char  = screen[cmd.read_row][cmd.read_col].glyph;
               rsp.cell_color = screen[cmd.read_row][cmd.read_col].attr;
            end
         end
         ACT_CLEAR: begin
            for (int r = 0; r < GRID_ROWS; r++) begin
               blank_row(r);
            end
            cur_row = 0;
            cur_col = 0;
         end
         default: begin
            // unused code: nothing changes, cursor reported as is
         end
      endcase
      rsp.cursor_row = ROW_IN_W'(cur_row);
      rsp.cursor_col = COL_IN_W'(cur_col);
      return rsp;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function void queue_cmd(logic [ACTION_W-1:0] act, logic [CHAR_W-1:0] ch,
                           logic [ROW_IN_W-1:0] row, logic [COL_IN_W-1:0] col);
      pending_cmd_type p;
      p.cmd = '{action: act, char_code: ch, read_row: row, read_col: col};
      p.lead_gap = (sender_idles && $urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
      queued_cmds.push_back(p);
   endfunction

   // Put with junk in the read fields, which a put ignores.
   function void queue_put(logic [CHAR_W-1:0] ch);
      queue_cmd(ACT_PUT, ch, ROW_IN_W'($urandom()), COL_IN_W'($urandom()));
   endfunction

   // In-grid read, leaning toward the bottom rows where fresh text sits.
   function void queue_grid_read();
      int unsigned row;
      row = ($urandom_range(0, 1) == 0) ? $urandom_range(GRID_ROWS - 5, GRID_ROWS - 1)
                                        : $urandom_range(0, GRID_ROWS - 1);
      queue_cmd(ACT_READ, CHAR_W'($urandom()), ROW_IN_W'(row),
                COL_IN_W'($urandom_range(0, GRID_COLS - 1)));
   endfunction

   // Queue one short sequence of commands; return how many were queued.
   task automatic add_segment(input bit allow_idle, output int added);
      int kind;
      int len;
      logic [CHAR_W-1:0] ch;
      added = 0;
      sender_idles = allow_idle && ($urandom_range(0, 2) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         // a run of text, now and then long enough to wrap at the last column
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(GRID_COLS - 4, GRID_COLS + 4)
                                           : $urandom_range(1, 40);
         repeat (len) begin
            ch = CHAR_W'($urandom());
            if (ch == NEWLINE_CODE) ch = SPACE_CODE;
            queue_put(ch);
         end
         added += len;
         if ($urandom_range(0, 1) == 0) begin
            queue_put(NEWLINE_CODE);
            added++;
         end
         len = $urandom_range(1, 4);
         repeat (len) queue_grid_read();
         added += len;
      end else if (kind < 57) begin
         // a burst of newlines to reach the bottom row and scroll
         len = $urandom_range(1, 12);
         repeat (len) queue_put(NEWLINE_CODE);
         queue_grid_read();
         added += len + 1;
      end else if (kind < 87) begin
         len = $urandom_range(1, 6);
         repeat (len) begin
            if ($urandom_range(0, 4) == 0)
               queue_cmd(ACT_READ, CHAR_W'($urandom()), ROW_IN_W'($urandom()),
                         COL_IN_W'($urandom()));
            else
               queue_grid_read();
         end
         added += len;
      end else if (kind < 95) begin
         queue_cmd(ACT_UNUSED, CHAR_W'($urandom()), ROW_IN_W'($urandom()),
                   COL_IN_W'($urandom()));
         added++;
      end else begin
         queue_cmd(ACT_CLEAR, CHAR_W'($urandom()), ROW_IN_W'($urandom()),
                   COL_IN_W'($urandom()));
         queue_grid_read();
         added += 2;
      end
   endtask

   // Wait until every queued command is sent, every reply is in and the
   // block has dropped busy.
   task automatic settle();
      do @(negedge clock);
      while (queued_cmds.size() != 0 || req_start || expected_replies.size() != 0 || busy);
   endtask

   // Write the text color; only called while the block is idle.
   task automatic write_color(input logic [COLOR_W-1:0] color);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= color;
      @(negedge clock);
      csr_write_en <= 1'b0;
      pen_color = color;
   endtask

   // ---------------------------------------------------------------------
   // Driver: present queued commands at the falling edge
   // ---------------------------------------------------------------------

   always @(negedge clock) begin
      pending_cmd_type nxt;
      logic launch;
      launch = 1'b0;
      // hold the current command until it is transferred
      if (!reset && (!req_start || req_taken)) begin
         req_taken = 1'b0;
         if (queued_cmds.size() != 0) begin
            if (queued_cmds[0].lead_gap > 0) begin
               queued_cmds[0].lead_gap = queued_cmds[0].lead_gap - 1;
            end else begin
               nxt = queued_cmds.pop_front();
               launch = 1'b1;
            end
         end
         req_start <= launch;
         if (launch) begin
            req_action    <= nxt.cmd.action;
            req_char_code <= nxt.cmd.char_code;
            req_read_row  <= nxt.cmd.read_row;
            req_read_col  <= nxt.cmd.read_col;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: record transfers and check replies at the rising edge
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      console_cmd_type seen;
      console_rsp_type want;
      console_rsp_type got;
      if (!reset) begin
         // predict first so a reply in the transfer cycle still finds its entry
         if (req_start && !busy) begin
            seen = '{action: req_action, char_code: req_char_code,
                     read_row: req_read_row, read_col: req_read_col};
            expected_replies.push_back(console_outcome(seen));
            req_taken = 1'b1;
            unique case (req_action)
               ACT_PUT:   put_count++;
               ACT_READ:  read_count++;
               ACT_CLEAR: clear_count++;
               default:   unused_count++;
            endcase
         end
         if (rsp_strobe) begin
            got = '{cell_char: rsp_cell_char, cell_color: rsp_cell_color,
                    cursor_row: rsp_cursor_row_out, cursor_col: rsp_cursor_col_out};
            reply_count++;
            if (expected_replies.size() == 0) begin
               $error("reply with no transfer outstanding");
               mismatch_count++;
            end else begin
               want = expected_replies.pop_front();
               if (got.cell_char !== want.cell_char) begin
                  $error("cell_char: expected %0d, actual %0d", want.cell_char, got.cell_char);
                  mismatch_count++;
               end
               if (got.cell_color !== want.cell_color) begin
                  $error("cell_color: expected %0d, actual %0d",
                         want.cell_color, got.cell_color);
                  mismatch_count++;
               end
               if (got.cursor_row !== want.cursor_row) begin
                  $error("cursor_row_out: expected %0d, actual %0d",
                         want.cursor_row, got.cursor_row);
                  mismatch_count++;
               end
               if (got.cursor_col !== want.cursor_col) begin
                  $error("cursor_col_out: expected %0d, actual %0d",
                         want.cursor_col, got.cursor_col);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence of phases
   // ---------------------------------------------------------------------

   initial begin
      int added;
      int phase_total;
      logic [COLOR_W-1:0] phase_color;

      reset          = 1'b1;
      req_start      = 1'b0;
      req_taken      = 1'b0;
      req_action     = ACT_PUT;
      req_char_code  = '0;
      req_read_row   = '0;
      req_read_col   = '0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      sender_idles   = 1'b1;

      // shadow console after reset: spaces in color 15, cursor home
      pen_color = RESET_COLOR;
      for (int r = 0; r < GRID_ROWS; r++) blank_row(r);
      cur_row = 0;
      cur_col = 0;

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed, reset color: corners, out-of-grid reads, extreme characters,
      // the unused code and a newline.
      queue_cmd(ACT_READ, 8'h00, 5'd0, 7'd0);
      queue_cmd(ACT_READ, 8'hFF, 5'(GRID_ROWS - 1), 7'(GRID_COLS - 1));
      queue_cmd(ACT_READ, 8'h00, 5'(GRID_ROWS), 7'd0);
      queue_cmd(ACT_READ, 8'h00, 5'd0, 7'(GRID_COLS));
      queue_cmd(ACT_READ, 8'h00, 5'h1F, 7'h7F);
      queue_put(8'h00);
      queue_put(8'hFF);
      queue_put(8'h41);
      queue_cmd(ACT_READ, 8'h00, 5'd0, 7'd1);
      queue_cmd(ACT_UNUSED, 8'hFF, 5'h1F, 7'h7F);
      queue_put(NEWLINE_CODE);
      queue_cmd(ACT_READ, 8'h00, 5'd0, 7'd2);
      queue_cmd(ACT_READ, 8'h00, 5'd1, 7'd0);
      settle();

      // Directed, color 0: a put, then a clear that blanks in the new color.
      write_color(8'h00);
      queue_put(8'h5A);
      queue_cmd(ACT_READ, 8'h00, 5'd1, 7'd0);
      queue_cmd(ACT_CLEAR, 8'hFF, 5'h1F, 7'h7F);
      queue_cmd(ACT_READ, 8'h00, 5'd1, 7'd0);
      queue_cmd(ACT_READ, 8'h00, 5'(GRID_ROWS - 1), 7'(GRID_COLS - 1));
      queue_cmd(ACT_UNUSED, 8'h00, 5'd0, 7'd0);
      settle();

      // Random phases, each under its own color; the last runs with no idling.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0:       phase_color = 8'hFF;
            2:       phase_color = 8'h00;
            default: phase_color = COLOR_W'($urandom());
         endcase
         write_color(phase_color);
         phase_total = 0;
         while (phase_total < PHASE_ITEMS) begin
            add_segment(ph != RANDOM_PHASES - 1, added);
            phase_total += added;
         end
         settle();
      end

      // drain: give any stray reply time to show up
      repeat (20) @(negedge clock);
      if (expected_replies.size() != 0) begin
         $error("%0d replies never arrived", expected_replies.size());
         mismatch_count++;
      end

      $display("Run covered %0d puts, %0d reads, %0d clears, %0d unused codes; %0d replies",
               put_count, read_count, clear_count, unused_count, reply_count);
      $display("Console saw %0d wraps at the last column and %0d scrolls",
               wrap_count, scroll_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog: stop a run that hangs on a lost transfer or reply.
   initial begin
      #(TIMEOUT_NS);
      $display("Run timed out with %0d replies outstanding", expected_replies.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
